// ===== rtl/mfde_pkg.sv =====
// Package for the monochrome framebuffer draw engine.
// Holds screen geometry, command codes and the walk/step structs.
// No dependencies.
`default_nettype none

package mfde_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = 8;
    localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int COL_W         = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int ADDR_W        = COL_W + 3;
    localparam int ERR_W         = 12;

    typedef enum logic [2:0] {
        MODE_POINT = 3'd0,
        MODE_LINE  = 3'd1,
        MODE_RECT  = 3'd2,
        MODE_FILL  = 3'd3,
        MODE_READ  = 3'd4
    } t_mode;

    // Current walk position and Bresenham terms
    typedef struct packed {
        logic              is_line;
        logic              x_neg;
        logic              y_neg;
        logic [7:0]        x;
        logic [7:0]        y;
        logic [7:0]        x_end;
        logic [7:0]        y_end;
        logic [7:0]        y_first;
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] dx;
        logic signed [ERR_W-1:0] dy;
    } t_walk;

    typedef struct packed {
        logic              done;
        logic [7:0]        x;
        logic [7:0]        y;
        logic signed [ERR_W-1:0] err;
    } t_step;

endpackage

`default_nettype wire

// ===== rtl/mono_framebuffer_draw_engine.sv =====
// Top level of the monochrome framebuffer draw engine: sequencer, pixel
// read-modify-write and output register. Uses mfde_pkg, mfde_step_unit and
// mfde_frame_ram.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------
//   command  | in        | i_valid / o_ready  | i_mode, coordinates, i_pixel_on, ...
//   result   | out       | o_valid / i_ready  | o_read_data, o_read_valid
//
// One command at a time. Point, line, rectangle: a RAM read and then a RAM write
// per pixel; fill: a write to each of the STORE_DEPTH bytes; read: a single read.
// Each pixel is a read-modify-write through the single RAM port.
// After reset the RAM is cleared one byte per cycle, with o_ready low.
// A waiting result does not block the next command; it blocks only its completion.
`default_nettype none

module mono_framebuffer_draw_engine (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_x_start,
    input  wire logic [7:0] i_y_start,
    input  wire logic [7:0] i_x_end,
    input  wire logic [7:0] i_y_end,
    input  wire logic       i_pixel_on,
    input  wire logic [7:0] i_fill_byte,
    input  wire logic [6:0] i_read_column,
    input  wire logic [2:0] i_read_page,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_read_data,
    output logic            o_read_valid
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_PLOT_RD,
        ST_PLOT_WR,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_FINISH
    } t_state;

    t_state                        r_state;
    logic [mfde_pkg::ADDR_W-1:0]   r_addr;
    logic [7:0]                    r_fill;
    logic                          r_on;
    logic [6:0]                    r_col;
    logic [2:0]                    r_page;
    logic [7:0]                    r_res_data;
    logic                          r_res_rv;
    logic                          r_out_valid;
    logic [7:0]                    r_out_data;
    logic                          r_out_rv;
    mfde_pkg::t_walk               r_walk;

    mfde_pkg::t_step               step;
    logic [mfde_pkg::ADDR_W-1:0]   ram_addr;
    logic                          ram_we;
    logic [7:0]                    ram_wdata;
    logic [7:0]                    ram_rdata;
    logic                          pix_on_screen;
    logic [2:0]                    pix_page;
    logic [7:0]                    pix_mask;
    logic [7:0]                    col_ext;
    logic                          read_ok;
    logic [7:0]                    abs_dx;
    logic [7:0]                    abs_dy;
    logic signed [mfde_pkg::ERR_W-1:0] init_dx;
    logic signed [mfde_pkg::ERR_W-1:0] init_dy;
    logic                          sweep_last;

    mfde_step_unit u_step (
        .i_walk (r_walk),
        .o_step (step)
    );

    mfde_frame_ram u_ram (
        .i_clk   (i_clk),
        .i_addr  (ram_addr),
        .i_we    (ram_we),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        pix_on_screen = ({1'b0, r_walk.x} < 9'(mfde_pkg::SCREEN_WIDTH))
                     && ({1'b0, r_walk.y} < 9'(mfde_pkg::SCREEN_HEIGHT));
        pix_page      = ~r_walk.y[5:3];
        pix_mask      = 8'h80 >> r_walk.y[2:0];
        col_ext       = {1'b0, r_col};
        read_ok       = ({1'b0, col_ext} < 9'(mfde_pkg::SCREEN_WIDTH));
        sweep_last    = (r_addr == mfde_pkg::ADDR_W'(mfde_pkg::STORE_DEPTH - 1));

        abs_dx  = (i_x_end > i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
        abs_dy  = (i_y_end > i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;
        init_dx = mfde_pkg::ERR_W'(abs_dx);
        init_dy = -mfde_pkg::ERR_W'(abs_dy);

        case (r_state)
            ST_CLEAR, ST_FILL: begin
                ram_addr = r_addr;
            end
            ST_READ_RD, ST_READ_WAIT: begin
                ram_addr = {col_ext[mfde_pkg::COL_W-1:0], r_page};
            end
            default: begin
                ram_addr = {r_walk.x[mfde_pkg::COL_W-1:0], pix_page};
            end
        endcase

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = 8'h00;
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = r_fill;
            end
            ST_PLOT_WR: begin
                ram_we    = pix_on_screen;
                ram_wdata = r_on ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
            end
            default: begin
                ram_we    = 1'b0;
                ram_wdata = ram_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR, ST_FILL: begin
                    r_addr <= sweep_last ? '0 : r_addr + 1'b1;
                    if (sweep_last) begin
                        r_state <= (r_state == ST_CLEAR) ? ST_IDLE : ST_FINISH;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_on           <= i_pixel_on;
                        r_res_data     <= 8'h00;
                        r_res_rv       <= (i_mode == mfde_pkg::MODE_READ);
                        r_walk.x       <= i_x_start;
                        r_walk.y       <= i_y_start;
                        r_walk.y_first <= i_y_start;
                        r_walk.x_end   <= (i_mode == mfde_pkg::MODE_POINT) ? i_x_start
                                                                           : i_x_end;
                        r_walk.y_end   <= (i_mode == mfde_pkg::MODE_POINT) ? i_y_start
                                                                           : i_y_end;
                        r_walk.x_neg   <= !(i_x_start < i_x_end);
                        r_walk.y_neg   <= !(i_y_start < i_y_end);
                        r_walk.dx      <= init_dx;
                        r_walk.dy      <= init_dy;
                        r_walk.err     <= init_dx + init_dy;
                        r_walk.is_line <= (i_mode != mfde_pkg::MODE_RECT);
                        case (i_mode)
                            mfde_pkg::MODE_POINT: begin
                                r_state <= ST_PLOT_RD;
                            end
                            mfde_pkg::MODE_LINE: begin
                                r_state <= ST_PLOT_RD;
                            end
                            mfde_pkg::MODE_RECT: begin
                                if ((i_x_start > i_x_end) || (i_y_start > i_y_end)) begin
                                    r_state <= ST_FINISH;
                                end else begin
                                    r_state <= ST_PLOT_RD;
                                end
                            end
                            mfde_pkg::MODE_FILL: begin
                                r_fill  <= i_fill_byte;
                                r_addr  <= '0;
                                r_state <= ST_FILL;
                            end
                            mfde_pkg::MODE_READ: begin
                                r_col   <= i_read_column;
                                r_page  <= i_read_page;
                                r_state <= ST_READ_RD;
                            end
                            default: begin
                                r_state <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_PLOT_RD: begin
                    r_state <= ST_PLOT_WR;
                end
                ST_PLOT_WR: begin
                    if (step.done) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_walk.x   <= step.x;
                        r_walk.y   <= step.y;
                        r_walk.err <= step.err;
                        r_state    <= ST_PLOT_RD;
                    end
                end
                ST_READ_RD: begin
                    r_state <= ST_READ_WAIT;
                end
                ST_READ_WAIT: begin
                    r_res_data <= read_ok ? ram_rdata : 8'h00;
                    r_state    <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res_data;
                        r_out_rv    <= r_res_rv;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_read_data  = r_out_data;
    assign o_read_valid = r_out_rv;

endmodule

`default_nettype wire

// ===== rtl/mfde_frame_ram.sv =====
// Frame store: single-port RAM, one byte per column/page, registered read.
// Depends on mfde_pkg for depth and address width.
`default_nettype none

module mfde_frame_ram (
    input  wire logic                     i_clk,
    input  wire logic [mfde_pkg::ADDR_W-1:0] i_addr,
    input  wire logic                     i_we,
    input  wire logic [7:0]               i_wdata,
    output logic      [7:0]               o_rdata
);

    logic [7:0] r_mem [mfde_pkg::STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/mfde_step_unit.sv =====
// Shared step unit: next pixel of a Bresenham line or a rectangle raster scan.
// Depends on mfde_pkg for t_walk and t_step.
`default_nettype none

module mfde_step_unit (
    input  wire mfde_pkg::t_walk i_walk,
    output mfde_pkg::t_step      o_step
);

    logic signed [mfde_pkg::ERR_W:0] e2;
    logic signed [mfde_pkg::ERR_W:0] dx_e;
    logic signed [mfde_pkg::ERR_W:0] dy_e;
    logic signed [mfde_pkg::ERR_W-1:0] add_x;
    logic signed [mfde_pkg::ERR_W-1:0] add_y;
    logic step_x;
    logic step_y;

    always_comb begin
        e2     = {i_walk.err, 1'b0};
        dx_e   = {i_walk.dx[mfde_pkg::ERR_W-1], i_walk.dx};
        dy_e   = {i_walk.dy[mfde_pkg::ERR_W-1], i_walk.dy};
        step_x = (e2 >= dy_e);
        step_y = (e2 <= dx_e);
        add_x  = step_x ? i_walk.dy : '0;
        add_y  = step_y ? i_walk.dx : '0;

        o_step.done = (i_walk.x == i_walk.x_end) && (i_walk.y == i_walk.y_end);
        o_step.err  = i_walk.err + add_x + add_y;
        o_step.x    = i_walk.x;
        o_step.y    = i_walk.y;

        if (i_walk.is_line) begin
            if (step_x) begin
                o_step.x = i_walk.x_neg ? i_walk.x - 8'd1 : i_walk.x + 8'd1;
            end
            if (step_y) begin
                o_step.y = i_walk.y_neg ? i_walk.y - 8'd1 : i_walk.y + 8'd1;
            end
        end else begin
            // column-major raster: y inner, x outer
            if (i_walk.y == i_walk.y_end) begin
                o_step.y = i_walk.y_first;
                o_step.x = i_walk.x + 8'd1;
            end else begin
                o_step.y = i_walk.y + 8'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/mono_framebuffer_draw_engine_tb.sv =====
// Testbench for mono_framebuffer_draw_engine: a queue-fed driver, a result monitor
// and a framebuffer predictor that replays each accepted command on its own copy.
// Depends on mfde_pkg and the RTL top level only.
`timescale 1ns / 100ps

module mono_framebuffer_draw_engine_tb;

    localparam int RANDOM_ITEMS   = 1200;
    localparam int TAIL_ITEMS     = 150;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int TIMEOUT_CYCLES = 10_000_000;

    localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] xs;
        logic [7:0] ys;
        logic [7:0] xe;
        logic [7:0] ye;
        logic       on;
        logic [7:0] fill;
        logic [6:0] col;
        logic [2:0] page;
        logic       wait_idle;
    } t_draw_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } t_draw_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [2:0] i_mode = '0;
    logic [7:0] i_x_start = '0;
    logic [7:0] i_y_start = '0;
    logic [7:0] i_x_end = '0;
    logic [7:0] i_y_end = '0;
    logic       i_pixel_on = 1'b0;
    logic [7:0] i_fill_byte = '0;
    logic [6:0] i_read_column = '0;
    logic [2:0] i_read_page = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_read_data;
    logic       o_read_valid;

    t_draw_cmd    cmd_backlog[$];
    t_draw_result expected_results[$];
    t_draw_cmd    cur_cmd;
    logic [7:0]   frame_img [0:mfde_pkg::STORE_DEPTH-1];

    int n_total;
    int n_sent;
    int n_results;
    int n_errors;
    int gap_left;
    int stall_left;
    int hold_left;
    int mode_hits [0:7];

    mono_framebuffer_draw_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_pixel_on    (i_pixel_on),
        .i_fill_byte   (i_fill_byte),
        .i_read_column (i_read_column),
        .i_read_page   (i_read_page),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data),
        .o_read_valid  (o_read_valid)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- framebuffer predictor ----------------

    function automatic void paint_pixel(int x, int y, logic on);
        int idx;
        logic [7:0] mask;
        if (x < 0 || y < 0 || x >= mfde_pkg::SCREEN_WIDTH || y >= mfde_pkg::SCREEN_HEIGHT)
            return;
        idx  = x * mfde_pkg::PAGE_COUNT + (7 - y / 8);
        mask = 8'h80 >> (y % 8);
        if (on) frame_img[idx] = frame_img[idx] | mask;
        else    frame_img[idx] = frame_img[idx] & ~mask;
    endfunction

    function automatic void trace_line(int x0, int y0, int x1, int y1, logic on);
        int  dx, dy, sx, sy, err, e2;
        bit  fin;
        dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy  = (y1 > y0) ? y0 - y1 : y1 - y0;
        sx  = (x0 < x1) ? 1 : -1;
        sy  = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        fin = 1'b0;
        while (!fin) begin
            paint_pixel(x0, y0, on);
            if (x0 == x1 && y0 == y1) begin
                fin = 1'b1;
            end else begin
                e2 = 2 * err;
                if (e2 >= dy) begin
                    err += dy;
                    x0  += sx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    y0  += sy;
                end
            end
        end
    endfunction

    function automatic void paint_box(int xa, int ya, int xb, int yb, logic on);
        for (int x = xa; x <= xb; x++)
            for (int y = ya; y <= yb; y++)
                paint_pixel(x, y, on);
    endfunction

    function automatic t_draw_result apply_command(t_draw_cmd c);
        t_draw_result r;
        r = '0;
        case (c.mode)
            mfde_pkg::MODE_POINT: paint_pixel(c.xs, c.ys, c.on);
            mfde_pkg::MODE_LINE:  trace_line(c.xs, c.ys, c.xe, c.ye, c.on);
            mfde_pkg::MODE_RECT:  paint_box(c.xs, c.ys, c.xe, c.ye, c.on);
            mfde_pkg::MODE_FILL:  foreach (frame_img[i]) frame_img[i] = c.fill;
            mfde_pkg::MODE_READ: begin
                r.valid = 1'b1;
                if (c.col < mfde_pkg::SCREEN_WIDTH)
                    r.data = frame_img[c.col * mfde_pkg::PAGE_COUNT + c.page];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- command builders ----------------

    function automatic int rand_x();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(0, mfde_pkg::SCREEN_WIDTH - 1);
    endfunction

    function automatic int rand_y();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(0, mfde_pkg::SCREEN_HEIGHT - 1);
    endfunction

    function automatic int clamp_coord(int v);
        return (v > 255) ? 255 : v;
    endfunction

    function automatic t_draw_cmd rand_cmd(logic [2:0] m);
        t_draw_cmd c;
        c.mode      = m;
        c.xs        = 8'($urandom_range(0, 255));
        c.ys        = 8'($urandom_range(0, 255));
        c.xe        = 8'($urandom_range(0, 255));
        c.ye        = 8'($urandom_range(0, 255));
        c.on        = 1'($urandom_range(0, 1));
        c.fill      = 8'($urandom_range(0, 255));
        c.col       = 7'($urandom_range(0, 127));
        c.page      = 3'($urandom_range(0, 7));
        c.wait_idle = 1'b0;
        return c;
    endfunction

    function automatic t_draw_cmd shape(logic [2:0] m, int xs, int ys, int xe, int ye,
                                        logic on);
        t_draw_cmd c;
        c    = rand_cmd(m);
        c.xs = 8'(xs);
        c.ys = 8'(ys);
        c.xe = 8'(xe);
        c.ye = 8'(ye);
        c.on = on;
        return c;
    endfunction

    function automatic t_draw_cmd read_at(int col, int page);
        t_draw_cmd c;
        c      = rand_cmd(mfde_pkg::MODE_READ);
        c.col  = 7'(col);
        c.page = 3'(page);
        return c;
    endfunction

    function automatic t_draw_cmd read_pixel(int x, int y);
        logic [7:0] yb;
        logic [2:0] pg;
        yb = 8'(y);
        pg = ~yb[5:3];
        return read_at(x % 128, int'(pg));
    endfunction

    function automatic t_draw_cmd fill_with(logic [7:0] b);
        t_draw_cmd c;
        c      = rand_cmd(mfde_pkg::MODE_FILL);
        c.fill = b;
        return c;
    endfunction

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(apply_command(cur_cmd));
                mode_hits[cur_cmd.mode]++;
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (cmd_backlog.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (cmd_backlog[0].wait_idle && expected_results.size() != 0) begin
                    i_valid <= 1'b0;
                end else if (n_sent < n_total - TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 3);
                    i_valid <= 1'b0;
                end else begin
                    cur_cmd = cmd_backlog.pop_front();
                    i_mode        <= cur_cmd.mode;
                    i_x_start     <= cur_cmd.xs;
                    i_y_start     <= cur_cmd.ys;
                    i_x_end       <= cur_cmd.xe;
                    i_y_end       <= cur_cmd.ye;
                    i_pixel_on    <= cur_cmd.on;
                    i_fill_byte   <= cur_cmd.fill;
                    i_read_column <= cur_cmd.col;
                    i_read_page   <= cur_cmd.page;
                    i_valid       <= 1'b1;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        t_draw_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: read_data %02h read_valid %0b",
                           o_read_data, o_read_valid);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_data !== want.data) begin
                        $error("read_data mismatch: expected %02h, got %02h",
                               want.data, o_read_data);
                        n_errors++;
                    end
                    if (o_read_valid !== want.valid) begin
                        $error("read_valid mismatch: expected %0b, got %0b",
                               want.valid, o_read_valid);
                        n_errors++;
                    end
                end
                n_results++;
                if (n_results == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (n_results < n_total - TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin
        int n_directed, sel, x, y, w, h;

        foreach (frame_img[i]) frame_img[i] = 8'h00;
        foreach (mode_hits[i]) mode_hits[i] = 0;
        n_sent     = 0;
        n_results  = 0;
        n_errors   = 0;
        gap_left   = 0;
        stall_left = 0;
        hold_left  = 0;

        cmd_backlog.push_back(read_at(127, 7));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_POINT, 0, 0, 0, 0, 1'b1));
        cmd_backlog.push_back(read_pixel(0, 0));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_POINT, 127, 63, 0, 0, 1'b1));
        cmd_backlog.push_back(read_pixel(127, 63));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_POINT, 128, 10, 0, 0, 1'b1));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_POINT, 10, 64, 0, 0, 1'b1));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_POINT, 255, 255, 255, 255, 1'b1));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_POINT, 0, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(read_pixel(0, 0));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_LINE, 5, 5, 5, 5, 1'b1));
        cmd_backlog.push_back(read_pixel(5, 5));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_LINE, 0, 0, 127, 63, 1'b1));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_LINE, 10, 60, 12, 0, 1'b1));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_LINE, 120, 5, 3, 9, 1'b0));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_LINE, 100, 30, 255, 255, 1'b1));
        cmd_backlog.push_back(read_pixel(100, 30));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, 20, 20, 10, 30, 1'b1));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, 30, 40, 40, 5, 1'b1));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, 0, 0, 255, 255, 1'b1));
        cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, 8, 8, 15, 15, 1'b0));
        cmd_backlog.push_back(read_pixel(8, 8));
        cmd_backlog.push_back(fill_with(8'hA5));
        cmd_backlog.push_back(fill_with(8'h5A));
        cmd_backlog.push_back(rand_cmd(MODE_UNUSED_5));
        cmd_backlog.push_back(rand_cmd(MODE_UNUSED_7));
        n_directed = cmd_backlog.size();

        while (cmd_backlog.size() < n_directed + RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            x   = rand_x();
            y   = rand_y();
            if (sel < 20) begin
                cmd_backlog.push_back(shape(mfde_pkg::MODE_POINT, x, y, rand_x(), rand_y(),
                                            1'($urandom_range(0, 1))));
                if ($urandom_range(0, 9) < 6) cmd_backlog.push_back(read_pixel(x, y));
            end else if (sel < 45) begin
                cmd_backlog.push_back(shape(mfde_pkg::MODE_LINE, x, y, rand_x(), rand_y(),
                                            1'($urandom_range(0, 1))));
                if ($urandom_range(0, 1)) cmd_backlog.push_back(read_pixel(x, y));
            end else if (sel < 60) begin
                w = $urandom_range(0, 15);
                h = $urandom_range(0, 15);
                cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, x, y, clamp_coord(x + w),
                                            clamp_coord(y + h), 1'($urandom_range(0, 1))));
                cmd_backlog.push_back(read_pixel(x + w / 2, y + h / 2));
            end else if (sel < 62) begin
                if ($urandom_range(0, 1)) begin
                    x = $urandom_range(0, 64);
                    cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, x, y,
                                                x + $urandom_range(0, 191),
                                                clamp_coord(y + $urandom_range(0, 3)),
                                                1'($urandom_range(0, 1))));
                end else begin
                    y = $urandom_range(0, 64);
                    cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, x, y,
                                                clamp_coord(x + $urandom_range(0, 3)),
                                                y + $urandom_range(0, 191),
                                                1'($urandom_range(0, 1))));
                end
            end else if (sel < 65) begin
                cmd_backlog.push_back(rand_cmd(mfde_pkg::MODE_FILL));
                cmd_backlog.push_back(rand_cmd(mfde_pkg::MODE_READ));
            end else if (sel < 67) begin
                cmd_backlog.push_back(rand_cmd(3'($urandom_range(MODE_UNUSED_5,
                                                                 MODE_UNUSED_7))));
            end else if (sel < 69) begin
                w = $urandom_range(1, 20);
                if ($urandom_range(0, 1))
                    cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, clamp_coord(x + w), y, x,
                                                clamp_coord(y + w), 1'b1));
                else
                    cmd_backlog.push_back(shape(mfde_pkg::MODE_RECT, x, clamp_coord(y + w),
                                                clamp_coord(x + w), y, 1'b1));
            end else begin
                cmd_backlog.push_back(rand_cmd(mfde_pkg::MODE_READ));
            end
        end
        cmd_backlog[n_directed].wait_idle = 1'b1;
        cmd_backlog[n_directed + RANDOM_ITEMS / 2].wait_idle = 1'b1;
        n_total = cmd_backlog.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands: %0d points, %0d lines, %0d rectangles, %0d fills,",
                 n_sent, mode_hits[mfde_pkg::MODE_POINT], mode_hits[mfde_pkg::MODE_LINE],
                 mode_hits[mfde_pkg::MODE_RECT], mode_hits[mfde_pkg::MODE_FILL]);
        $display("%0d byte reads, %0d unused-mode commands; %0d results checked, %0d errors.",
                 mode_hits[mfde_pkg::MODE_READ], mode_hits[MODE_UNUSED_5]
                 + mode_hits[MODE_UNUSED_6] + mode_hits[MODE_UNUSED_7], n_results, n_errors);
        if (n_errors == 0) begin
            $display("PASS mono_framebuffer_draw_engine");
        end else begin
            $display("FAIL mono_framebuffer_draw_engine");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("Timeout: %0d of %0d commands sent, %0d results seen.",
                 n_sent, n_total, n_results);
        $display("FAIL mono_framebuffer_draw_engine");
        $finish;
    end

endmodule
